// ===== design/uarttx_pkg.sv =====
// Shared types and constants for the UART transmit ring with RS-485 driver enable.
package uarttx_pkg;

  localparam int DATA_W  = 8;
  localparam int SLOTS_W = 5;
  localparam int DROP_W  = 32;

  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic push;
    logic start_svc;
    logic pop;
    logic status;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic can_send;
    logic more;
  } sts_t;

endpackage

// ===== design/uarttx_in_if.sv =====
// Input channel: push or service items.
interface uarttx_in_if;
  import uarttx_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [DATA_W-1:0]  tx_data;
  logic               block_end;
  logic [SLOTS_W-1:0] ready_slots;
  logic               tx_complete;

  modport source (output valid, op, tx_data, block_end, ready_slots, tx_complete,
                  input ready);
  modport sink   (input valid, op, tx_data, block_end, ready_slots, tx_complete,
                  output ready);
endinterface

// ===== design/uarttx_out_if.sv =====
// Result channel: push acknowledges, sent bytes and tick status.
interface uarttx_out_if #(
  parameter int FILL_W = 8
);
  import uarttx_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [DATA_W-1:0] sent_byte;
  logic              accepted;
  logic              block_end_echo;
  logic              driver_enable;
  logic [FILL_W-1:0] fill_level;
  logic [DROP_W-1:0] dropped_total;
  logic              last;

  modport source (output valid, kind, sent_byte, accepted, block_end_echo, driver_enable,
                  fill_level, dropped_total, last, input ready);
  modport sink   (input valid, kind, sent_byte, accepted, block_end_echo, driver_enable,
                  fill_level, dropped_total, last, output ready);
endinterface

// ===== design/uarttx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module uarttx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== design/uarttx_ctrl.sv =====
// Controller state machine: sequences push, fetch, byte transfers and tick status.
module uarttx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  uarttx_pkg::sts_t  sts,
  output uarttx_pkg::cmd_t  cmd
);
  import uarttx_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_xfer;

  assign in_ready = (state_r == ST_IDLE) && sts.slot_free;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_PUSH) begin
            cmd.push = 1'b1;
          end else begin
            cmd.start_svc = 1'b1;
            state_nxt     = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = sts.can_send ? ST_EMIT : ST_STATUS;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.pop   = 1'b1;
          state_nxt = sts.more ? ST_EMIT : ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (sts.slot_free) begin
          cmd.status = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== design/uarttx_dp.sv =====
// Datapath: byte ring, indexes, counters, driver enable and result register.
module uarttx_dp #(
  parameter int RING_DEPTH  = 128,
  parameter int BURST_LIMIT = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_data,
  input  logic [uarttx_pkg::DATA_W-1:0]         in_tx_data,
  input  logic                                  in_block_end,
  input  logic [uarttx_pkg::SLOTS_W-1:0]        in_ready_slots,
  input  logic                                  in_tx_complete,
  input  uarttx_pkg::cmd_t                      cmd,
  output uarttx_pkg::sts_t                      sts,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output uarttx_pkg::kind_t                     out_kind,
  output logic [uarttx_pkg::DATA_W-1:0]         out_sent_byte,
  output logic                                  out_accepted,
  output logic                                  out_block_end_echo,
  output logic                                  out_driver_enable,
  output logic [$clog2(RING_DEPTH+1)-1:0]       out_fill_level,
  output logic [uarttx_pkg::DROP_W-1:0]         out_dropped_total,
  output logic                                  out_last
);
  import uarttx_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH+1);

  logic               rs485_r,  rs485_nxt;
  logic               active_r, active_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic [DROP_W-1:0]  drop_r,   drop_nxt;
  logic [SLOTS_W-1:0] limit_r,  limit_nxt;
  logic [SLOTS_W-1:0] sent_r,   sent_nxt;
  logic               tc_r,     tc_nxt;
  logic               ovld_r,   ovld_nxt;

  kind_t              kind_r,  kind_nxt;
  logic [DATA_W-1:0]  byte_r,  byte_nxt;
  logic               acc_r,   acc_nxt;
  logic               echo_r,  echo_nxt;
  logic               last_r,  last_nxt;

  logic               full;
  logic               ram_we;
  logic [DATA_W-1:0]  ram_rdata;
  logic               load;

  assign full   = (count_r == CNT_W'(RING_DEPTH));
  assign ram_we = cmd.push && !full;
  assign load   = cmd.push || cmd.pop || cmd.status;

  uarttx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (in_tx_data),
    .raddr (rd_idx_nxt),
    .rdata (ram_rdata)
  );

  assign sts.slot_free = !ovld_r || out_ready;
  assign sts.can_send  = (count_r != '0) && (sent_r < limit_r) && (!rs485_r || active_r);
  assign sts.more      = (count_r > CNT_W'(1)) &&
                         (({1'b0, sent_r} + 1'b1) < {1'b0, limit_r});

  always_comb begin
    rs485_nxt  = rs485_r;
    active_nxt = active_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    drop_nxt   = drop_r;
    limit_nxt  = limit_r;
    sent_nxt   = sent_r;
    tc_nxt     = tc_r;
    ovld_nxt   = ovld_r && !out_ready;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    acc_nxt    = acc_r;
    echo_nxt   = echo_r;
    last_nxt   = last_r;

    if (cmd.push) begin
      if (full) begin
        drop_nxt = drop_r + 1'b1;
      end else begin
        wr_idx_nxt = (wr_idx_r == IDX_W'(RING_DEPTH-1)) ? '0 : wr_idx_r + 1'b1;
        count_nxt  = count_r + 1'b1;
      end
      kind_nxt = KIND_ACK;
      byte_nxt = '0;
      acc_nxt  = !full;
      echo_nxt = in_block_end;
      last_nxt = 1'b1;
    end

    if (cmd.start_svc) begin
      limit_nxt = (int'(in_ready_slots) > BURST_LIMIT) ? SLOTS_W'(BURST_LIMIT)
                                                        : in_ready_slots;
      sent_nxt  = '0;
      tc_nxt    = in_tx_complete;
      if (rs485_r && !active_r && (count_r != '0)) begin
        active_nxt = 1'b1;
      end
    end

    if (cmd.pop) begin
      rd_idx_nxt = (rd_idx_r == IDX_W'(RING_DEPTH-1)) ? '0 : rd_idx_r + 1'b1;
      count_nxt  = count_r - 1'b1;
      sent_nxt   = sent_r + 1'b1;
      kind_nxt   = KIND_BYTE;
      byte_nxt   = ram_rdata;
      acc_nxt    = 1'b0;
      echo_nxt   = 1'b0;
      last_nxt   = 1'b0;
    end

    if (cmd.status) begin
      if (rs485_r && (count_r == '0) && tc_r) begin
        active_nxt = 1'b0;
      end
      kind_nxt = KIND_STATUS;
      byte_nxt = '0;
      acc_nxt  = 1'b0;
      echo_nxt = 1'b0;
      last_nxt = 1'b1;
    end

    if (load) begin
      ovld_nxt = 1'b1;
    end

    // mode write forces the driver off
    if (cfg_we) begin
      rs485_nxt  = cfg_data;
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs485_r  <= 1'b0;
      active_r <= 1'b0;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
      drop_r   <= '0;
      limit_r  <= '0;
      sent_r   <= '0;
      tc_r     <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      rs485_r  <= rs485_nxt;
      active_r <= active_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
      drop_r   <= drop_nxt;
      limit_r  <= limit_nxt;
      sent_r   <= sent_nxt;
      tc_r     <= tc_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  logic               de_r;
  logic [CNT_W-1:0]   fill_r;
  logic [DROP_W-1:0]  dtot_r;

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    acc_r  <= acc_nxt;
    echo_r <= echo_nxt;
    last_r <= last_nxt;
    if (load) begin
      de_r   <= active_nxt;
      fill_r <= count_nxt;
      dtot_r <= drop_nxt;
    end
  end

  assign out_valid          = ovld_r;
  assign out_kind           = kind_r;
  assign out_sent_byte      = byte_r;
  assign out_accepted       = acc_r;
  assign out_block_end_echo = echo_r;
  assign out_driver_enable  = de_r;
  assign out_fill_level     = fill_r;
  assign out_dropped_total  = dtot_r;
  assign out_last           = last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RING_DEPTH))
    else $error("ring fill count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0) && (sent_r < limit_r))
    else $error("byte transfer from empty ring or past burst limit");

  a_cfg_clears_de: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !active_r)
    else $error("driver enable still high after mode write");

  a_push_wr_only: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.push && !cfg_we |=> $stable(wr_idx_r) && $stable(drop_r))
    else $error("write index or drop count moved without a push");
`endif
endmodule

// ===== design/uart_tx_fifo_rs485_direction.sv =====
// Top level: UART transmit byte ring with RS-485 driver-enable control.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      op, tx_data, block_end, ready_slots, tx_complete
//  out_ch   out  valid/ready      kind, sent_byte, accepted, block_end_echo,
//                                 driver_enable, fill_level, dropped_total, last
//  cfg      in   cfg_we           cfg_data (rs485_enable)
//
// Pushes stream at one per cycle while out_ch drains.
// A service tick steps through accept, ring read, a transfer of each byte from the
// ring RAM's registered read port, then status.
// A stalled out_ch holds its result; in_ch is ready only between ticks.
// rst_n is synchronous; ring contents are not cleared.
module uart_tx_fifo_rs485_direction #(
  parameter int RING_DEPTH  = 128,
  parameter int BURST_LIMIT = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  uarttx_in_if.sink    in_ch,
  uarttx_out_if.source out_ch,
  input  logic         cfg_we,
  input  logic         cfg_data
);
  import uarttx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  uarttx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uarttx_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .BURST_LIMIT (BURST_LIMIT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_tx_data         (in_ch.tx_data),
    .in_block_end       (in_ch.block_end),
    .in_ready_slots     (in_ch.ready_slots),
    .in_tx_complete     (in_ch.tx_complete),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_kind           (out_ch.kind),
    .out_sent_byte      (out_ch.sent_byte),
    .out_accepted       (out_ch.accepted),
    .out_block_end_echo (out_ch.block_end_echo),
    .out_driver_enable  (out_ch.driver_enable),
    .out_fill_level     (out_ch.fill_level),
    .out_dropped_total  (out_ch.dropped_total),
    .out_last           (out_ch.last)
  );
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the UART transmit ring with RS-485 driver enable.
module tb_top;
  import uarttx_pkg::*;

  localparam int RING   = 128;
  localparam int BURST  = 16;
  localparam int SETTLE = 6;

  typedef struct packed {
    logic               op;
    logic [DATA_W-1:0]  data;
    logic               bend;
    logic [SLOTS_W-1:0] slots;
    logic               tc;
  } tx_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] sent_byte;
    logic              accepted;
    logic              bend_echo;
    logic              drv_en;
    logic [7:0]        fill;
    logic [DROP_W-1:0] drops;
    logic              last;
  } tx_result_t;

  class tx_ring_tracker;
    logic [DATA_W-1:0] ring [RING];
    int unsigned       wr_ptr, rd_ptr, level;
    logic [DROP_W-1:0] drops;
    bit                active, rs485;
    tx_result_t        due[$];
    int unsigned       errors, pushes, ticks, bytes_sent, checked;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      level = 0;
      drops = '0;
      active = 0;
      rs485 = 0;
      errors = 0;
      pushes = 0;
      ticks = 0;
      bytes_sent = 0;
      checked = 0;
    endfunction

    function void set_mode(bit mode);
      rs485 = mode;
      active = 0;
    endfunction

    function void add(kind_t k, logic [DATA_W-1:0] b, logic acc, logic echo, logic last);
      tx_result_t r;
      r.kind = k;
      r.sent_byte = b;
      r.accepted = acc;
      r.bend_echo = echo;
      r.drv_en = active;
      r.fill = level[7:0];
      r.drops = drops;
      r.last = last;
      due.push_back(r);
    endfunction

    function void note_item(tx_item_t it);
      int unsigned       limit, n;
      logic [DATA_W-1:0] b;
      if (it.op == OP_PUSH) begin
        pushes++;
        if (level >= RING) begin
          drops++;
          add(KIND_ACK, '0, 1'b0, it.bend, 1'b1);
        end else begin
          ring[wr_ptr] = it.data;
          wr_ptr = (wr_ptr + 1) % RING;
          level++;
          add(KIND_ACK, '0, 1'b1, it.bend, 1'b1);
        end
      end else begin
        ticks++;
        limit = (it.slots > BURST) ? BURST : it.slots;
        if (rs485 && !active && level > 0) active = 1;
        if (!rs485 || active) begin
          n = 0;
          while (level > 0 && n < limit) begin
            b = ring[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING;
            level--;
            n++;
            bytes_sent++;
            add(KIND_BYTE, b, 1'b0, 1'b0, 1'b0);
          end
          if (rs485 && level == 0 && it.tc) active = 0;
        end
        add(KIND_STATUS, '0, 1'b0, 1'b0, 1'b1);
      end
    endfunction

    function void cmp(string field, logic [DROP_W-1:0] e, logic [DROP_W-1:0] a);
      if (a !== e) begin
        $error("%s: expected %0d, actual %0d", field, e, a);
        errors++;
      end
    endfunction

    function void check_result(tx_result_t got);
      tx_result_t exp;
      if (due.size() == 0) begin
        $error("result with nothing expected: kind %0d", got.kind);
        errors++;
        return;
      end
      exp = due.pop_front();
      checked++;
      cmp("kind", exp.kind, got.kind);
      cmp("sent_byte", exp.sent_byte, got.sent_byte);
      cmp("accepted", exp.accepted, got.accepted);
      cmp("block_end_echo", exp.bend_echo, got.bend_echo);
      cmp("driver_enable", exp.drv_en, got.drv_en);
      cmp("fill_level", exp.fill, got.fill);
      cmp("dropped_total", exp.drops, got.drops);
      cmp("last", exp.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_data;
  logic hold;
  int unsigned idle_pct, stall_pct;
  tx_ring_tracker sb;
  tx_result_t seen;

  uarttx_in_if in_ch();
  uarttx_out_if #(.FILL_W(8)) out_ch();

  uart_tx_fifo_rs485_direction #(
    .RING_DEPTH(RING),
    .BURST_LIMIT(BURST)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= !hold && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.kind = out_ch.kind;
      seen.sent_byte = out_ch.sent_byte;
      seen.accepted = out_ch.accepted;
      seen.bend_echo = out_ch.block_end_echo;
      seen.drv_en = out_ch.driver_enable;
      seen.fill = out_ch.fill_level;
      seen.drops = out_ch.dropped_total;
      seen.last = out_ch.last;
      sb.check_result(seen);
    end
  end

  task automatic send(tx_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.tx_data <= it.data;
    in_ch.block_end <= it.bend;
    in_ch.ready_slots <= it.slots;
    in_ch.tx_complete <= it.tc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic push(logic [DATA_W-1:0] d, logic be);
    tx_item_t it;
    it.op = OP_PUSH;
    it.data = d;
    it.bend = be;
    it.slots = SLOTS_W'($urandom_range(31));
    it.tc = 1'($urandom_range(1));
    send(it);
  endtask

  task automatic tick(logic [SLOTS_W-1:0] s, logic tc);
    tx_item_t it;
    it.op = OP_SERVICE;
    it.data = DATA_W'($urandom_range(255));
    it.bend = 1'($urandom_range(1));
    it.slots = s;
    it.tc = tc;
    send(it);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(bit mode);
    quiesce();
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(mode);
  endtask

  // mostly framed blocks of pushes followed by service ticks, some stray items
  task automatic random_traffic(int unsigned n);
    int unsigned done, k, len, nt;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1))
          push(DATA_W'($urandom_range(255)), 1'($urandom_range(1)));
        else
          tick(SLOTS_W'($urandom_range(31)), 1'($urandom_range(1)));
        done++;
      end else begin
        len = $urandom_range(12, 1);
        for (k = 0; k < len; k++) push(DATA_W'($urandom_range(255)), k == len - 1);
        nt = $urandom_range(3, 1);
        for (k = 0; k < nt; k++)
          tick(SLOTS_W'($urandom_range(31)), 1'($urandom_range(99) < 70));
        done += len + nt;
      end
    end
  endtask

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int p;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    hold = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PUSH;
    in_ch.tx_data = '0;
    in_ch.block_end = 1'b0;
    in_ch.ready_slots = '0;
    in_ch.tx_complete = 1'b0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // full-duplex basics, slot clamp, empty ring
    write_mode(1'b0);
    push(8'h00, 1'b1);
    push(8'hFF, 1'b0);
    push(8'hA5, 1'b1);
    push(8'h5A, 1'b0);
    tick(5'd0, 1'b0);
    tick(5'd31, 1'b1);
    tick(5'd16, 1'b0);

    // driver enable rise and fall
    write_mode(1'b1);
    tick(5'd5, 1'b1);
    push(8'h3C, 1'b0);
    push(8'hC3, 1'b1);
    push(8'h81, 1'b0);
    tick(5'd2, 1'b1);
    push(8'h7E, 1'b1);
    tick(5'd16, 1'b0);
    tick(5'd0, 1'b1);
    push(8'h42, 1'b0);
    tick(5'd1, 1'b1);
    push(8'h24, 1'b1);
    tick(5'd0, 1'b0);
    write_mode(1'b1);
    tick(5'd1, 1'b0);
    write_mode(1'b0);
    tick(5'd16, 1'b1);

    // overfill the ring; a hold on the result side stalls the pushes at first
    write_mode(1'b1);
    fork
      begin
        hold <= 1'b1;
        repeat (400) @(posedge clk);
        hold <= 1'b0;
      end
    join_none
    repeat (136) push(DATA_W'($urandom_range(255)), 1'($urandom_range(1)));
    while (sb.level > 0) tick(SLOTS_W'($urandom_range(31, 16)), 1'($urandom_range(1)));
    tick(5'd16, 1'b1);

    for (p = 0; p < 4; p++) begin
      write_mode(p[0]);
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      random_traffic(12);
    end

    quiesce();
    $display("Run covered %0d pushes (%0d dropped on a full ring) and %0d service ticks",
             sb.pushes, sb.drops, sb.ticks);
    $display("sending %0d bytes; %0d results checked in both driver modes.",
             sb.bytes_sent, sb.checked);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
